@@ hdl/rpn_pkg.sv @@
// Shared constants and types for the postfix expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
package rpn_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 16;
    localparam int OUT_WIDTH   = 16;

    localparam int PTR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_OVER    = 3'd2;
    localparam logic [2:0] ST_DIVZ    = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;

    typedef struct packed {
        logic start;
        logic is_div;
    } rpn_mdu_req_t;

endpackage
`default_nettype wire

@@ hdl/rpn_mdu.sv @@
// Iterative multiply / signed divide unit, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rpn_mdu (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire rpn_pkg::rpn_mdu_req_t             req,
    input  wire logic [rpn_pkg::VALUE_WIDTH-1:0]   op_a,
    input  wire logic [rpn_pkg::VALUE_WIDTH-1:0]   op_b,
    output logic                                   done,
    output logic [rpn_pkg::VALUE_WIDTH-1:0]        result
);
    import rpn_pkg::*;

    logic                   busy_reg;
    logic                   div_reg;
    logic                   neg_reg;
    logic                   done_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    logic [VALUE_WIDTH-1:0] lo_reg;
    logic [VALUE_WIDTH-1:0] dvs_reg;
    logic [VALUE_WIDTH-1:0] result_reg;

    logic [VALUE_WIDTH-1:0] abs_a;
    logic [VALUE_WIDTH-1:0] abs_b;
    logic [VALUE_WIDTH:0]   rem_sh;
    logic [VALUE_WIDTH:0]   diff;

    assign abs_a  = op_a[VALUE_WIDTH-1] ? (~op_a + 1'b1) : op_a;
    assign abs_b  = op_b[VALUE_WIDTH-1] ? (~op_b + 1'b1) : op_b;
    assign rem_sh = {acc_reg, lo_reg[VALUE_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (req.start && !busy_reg) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            div_reg  <= req.is_div;
            step_reg <= '0;
            acc_reg  <= '0;
            if (req.is_div) begin
                lo_reg  <= abs_a;
                dvs_reg <= abs_b;
                neg_reg <= op_a[VALUE_WIDTH-1] ^ op_b[VALUE_WIDTH-1];
            end else begin
                lo_reg  <= op_b;
                dvs_reg <= op_a;
                neg_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            if (step_reg == STEP_W'(VALUE_WIDTH)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
                if (div_reg) begin
                    result_reg <= neg_reg ? (~lo_reg + 1'b1) : lo_reg;
                end else begin
                    result_reg <= acc_reg;
                end
            end else begin
                done_reg <= 1'b0;
                step_reg <= step_reg + 1'b1;
                if (div_reg) begin
                    if (!diff[VALUE_WIDTH]) begin
                        acc_reg <= diff[VALUE_WIDTH-1:0];
                    end else begin
                        acc_reg <= rem_sh[VALUE_WIDTH-1:0];
                    end
                    lo_reg <= {lo_reg[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
                end else begin
                    if (lo_reg[0]) begin
                        acc_reg <= acc_reg + dvs_reg;
                    end
                    dvs_reg <= {dvs_reg[VALUE_WIDTH-2:0], 1'b0};
                    lo_reg  <= {1'b0, lo_reg[VALUE_WIDTH-1:1]};
                end
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire

@@ hdl/postfix_expression_evaluator_top.sv @@
// Postfix (RPN) expression evaluator: token sequencer, operand stack and shared unit.
`timescale 1ns / 1ps
`default_nettype none
// Takes one ASCII token per transaction. A digit is handled in S_IDLE; + and - read
// the stack memory in S_IDLE, then add in S_OPER; * and / pass through S_OPER to
// S_WAIT, where the bit-serial multiply/divide unit runs, except that a zero divisor ends in S_OPER.
// Invalid tokens, underflow and tokens after an error end in S_IDLE. A token marked
// last then passes through S_FINISH to emit the result, and waits there while a
// previous result has not been taken. The top of stack lives in a register, the
// words below it in a single-port-write memory.
// Status is sticky per expression; value reads 0 whenever status is not ok.
module postfix_expression_evaluator_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_token,
    input  wire logic               s_last_token,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_value,
    output logic [2:0]              m_status
);
    import rpn_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_OPER, S_WAIT, S_FINISH} state_t;
    typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;

    state_t                 state_reg;
    op_t                    op_reg;
    op_t                    op_dec;
    logic                   last_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [2:0]             err_reg;
    logic [VALUE_WIDTH-1:0] tos_reg;
    logic                   m_valid_reg;
    logic [OUT_WIDTH-1:0]   m_value_reg;
    logic [2:0]             m_status_reg;

    logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    logic                   is_digit;
    logic                   is_op;
    logic                   accept;
    logic                   wr_en;
    logic                   rd_en;
    logic [CNT_W-1:0]       cnt_m1;
    logic [CNT_W-1:0]       cnt_m2;
    logic [VALUE_WIDTH-1:0] digit_val;
    logic [OUT_WIDTH+VALUE_WIDTH-1:0] tos_ext;
    state_t                 tail_state;
    state_t                 idle_exit;

    rpn_mdu_req_t           mdu_req;
    logic                   mdu_done;
    logic [VALUE_WIDTH-1:0] mdu_result;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_digit = (s_token >= CH_ZERO) && (s_token <= CH_NINE);
    assign is_op    = (s_token == CH_PLUS) || (s_token == CH_MINUS) ||
                      (s_token == CH_TIMES) || (s_token == CH_DIV);
    assign cnt_m1   = count_reg - 1'b1;
    assign cnt_m2   = count_reg - 2'd2;
    assign digit_val = {{(VALUE_WIDTH-4){1'b0}}, s_token[3:0]};
    assign tos_ext  = {{OUT_WIDTH{1'b0}}, tos_reg};
    assign tail_state = last_reg ? S_FINISH : S_IDLE;
    assign idle_exit  = s_last_token ? S_FINISH : S_IDLE;

    always_comb begin
        case (s_token)
            CH_PLUS:  op_dec = OP_ADD;
            CH_MINUS: op_dec = OP_SUB;
            CH_TIMES: op_dec = OP_MUL;
            default:  op_dec = OP_DIV;
        endcase
    end

    assign wr_en = accept && (err_reg == ST_OK) && is_digit &&
                   (count_reg != '0) && (count_reg != CNT_W'(STACK_DEPTH));
    assign rd_en = accept && (err_reg == ST_OK) && is_op && (count_reg >= CNT_W'(2));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[cnt_m1[PTR_W-1:0]] <= tos_reg;
        end
        if (rd_en) begin
            rd_data_reg <= stack_mem[cnt_m2[PTR_W-1:0]];
        end
    end

    assign mdu_req.start  = (state_reg == S_OPER) &&
                            ((op_reg == OP_MUL) || ((op_reg == OP_DIV) && (tos_reg != '0)));
    assign mdu_req.is_div = (op_reg == OP_DIV);

    rpn_mdu u_mdu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mdu_req),
        .op_a    (rd_data_reg),
        .op_b    (tos_reg),
        .done    (mdu_done),
        .result  (mdu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        last_reg  <= s_last_token;
                        if (err_reg != ST_OK) begin
                            state_reg <= idle_exit;
                        end else if (is_digit) begin
                            state_reg <= idle_exit;
                            if (count_reg == CNT_W'(STACK_DEPTH)) begin
                                err_reg <= ST_OVER;
                            end else begin
                                tos_reg   <= digit_val;
                                count_reg <= count_reg + 1'b1;
                            end
                        end else if (!is_op) begin
                            err_reg   <= ST_INVALID;
                            state_reg <= idle_exit;
                        end else if (count_reg < CNT_W'(2)) begin
                            err_reg   <= ST_UNDER;
                            state_reg <= idle_exit;
                        end else begin
                            op_reg    <= op_dec;
                            state_reg <= S_OPER;
                        end
                    end
                end
                S_OPER: begin
                    case (op_reg)
                        OP_ADD: begin
                            tos_reg   <= rd_data_reg + tos_reg;
                            count_reg <= cnt_m1;
                            state_reg <= tail_state;
                        end
                        OP_SUB: begin
                            tos_reg   <= rd_data_reg - tos_reg;
                            count_reg <= cnt_m1;
                            state_reg <= tail_state;
                        end
                        OP_MUL: begin
                            state_reg <= S_WAIT;
                        end
                        default: begin
                            if (tos_reg == '0) begin
                                err_reg   <= ST_DIVZ;
                                state_reg <= tail_state;
                            end else begin
                                state_reg <= S_WAIT;
                            end
                        end
                    endcase
                end
                S_WAIT: begin
                    if (mdu_done) begin
                        tos_reg   <= mdu_result;
                        count_reg <= cnt_m1;
                        state_reg <= tail_state;
                    end
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        if (err_reg != ST_OK) begin
                            m_status_reg <= err_reg;
                            m_value_reg  <= '0;
                        end else if (count_reg == '0) begin
                            m_status_reg <= ST_UNDER;
                            m_value_reg  <= '0;
                        end else begin
                            m_status_reg <= ST_OK;
                            m_value_reg  <= tos_ext[OUT_WIDTH-1:0];
                        end
                        count_reg <= '0;
                        err_reg   <= ST_OK;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_err_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_value == '0))
        else $error("nonzero value with error status");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mdu_done |-> (state_reg == S_WAIT))
        else $error("unit done outside wait");

    a_no_start_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_OK) |-> !mdu_req.start)
        else $error("unit started with sticky error");

    a_oper_two_words: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OPER) |-> (count_reg >= CNT_W'(2)))
        else $error("operator issued with fewer than two words");

endmodule
`default_nettype wire

@@ sim/postfix_expression_evaluator_top_test.sv @@
// Self-checking testbench for the postfix expression evaluator: token driver, result monitor.
`timescale 1ns / 1ps
module postfix_expression_evaluator_top_test;
    import rpn_pkg::*;

    localparam int RANDOM_ITEMS   = 1300;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 50;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [7:0] token;
        logic       last;
        bit         hold;
    } token_item_t;

    typedef struct {
        logic signed [OUT_WIDTH-1:0] value;
        logic [2:0]                  status;
    } calc_result_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [7:0]                  s_token = 8'h00;
    logic                        s_last_token = 1'b0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [OUT_WIDTH-1:0] m_value;
    logic [2:0]                  m_status;

    token_item_t  token_queue[$];
    calc_result_t expected_results[$];
    logic [7:0]   expr_buf[$];
    bit           drain_next = 1'b0;
    int           total_items = 0;
    int           accepted_count = 0;
    int           fail_count = 0;
    int           send_gap = 0;
    int           ready_gap = 0;
    int           idle_cycles = 0;
    token_item_t  next_tx;
    calc_result_t want;
    calc_result_t got;
    bit           emits;

    // Shadow of the operand stack and sticky error.
    logic [VALUE_WIDTH-1:0] calc_stack[STACK_DEPTH];
    int                     calc_depth = 0;
    logic [2:0]             calc_err = ST_OK;

    postfix_expression_evaluator_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_token      (s_token),
        .s_last_token (s_last_token),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_status     (m_status)
    );

    always #1 aclk = ~aclk;

    function automatic logic [7:0] digit(int n);
        return CH_ZERO + 8'(n);
    endfunction

    function automatic logic [7:0] random_op();
        case ($urandom_range(0, 3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_TIMES;
            default: return CH_DIV;
        endcase
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] trunc_div(logic [VALUE_WIDTH-1:0] a,
                                                         logic [VALUE_WIDTH-1:0] b);
        logic [VALUE_WIDTH-1:0] ma;
        logic [VALUE_WIDTH-1:0] mb;
        logic [VALUE_WIDTH-1:0] q;
        ma = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
        mb = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;
        q = ma / mb;
        if (a[VALUE_WIDTH-1] != b[VALUE_WIDTH-1]) begin
            q = ~q + 1'b1;
        end
        return q;
    endfunction

    function automatic void stack_push(logic [VALUE_WIDTH-1:0] w);
        if (calc_depth >= STACK_DEPTH) begin
            calc_err = ST_OVER;
        end else begin
            calc_stack[calc_depth] = w;
            calc_depth++;
        end
    endfunction

    function automatic void apply_token(logic [7:0] tok);
        logic [VALUE_WIDTH-1:0] m;
        logic [VALUE_WIDTH-1:0] n;
        logic [VALUE_WIDTH-1:0] r;
        if (tok >= CH_ZERO && tok <= CH_NINE) begin
            stack_push(VALUE_WIDTH'(tok - CH_ZERO));
            return;
        end
        if (tok != CH_PLUS && tok != CH_MINUS && tok != CH_TIMES && tok != CH_DIV) begin
            calc_err = ST_INVALID;
            return;
        end
        if (calc_depth < 2) begin
            calc_err = ST_UNDER;
            return;
        end
        n = calc_stack[calc_depth-1];
        m = calc_stack[calc_depth-2];
        if (tok == CH_PLUS) begin
            r = m + n;
        end else if (tok == CH_MINUS) begin
            r = m - n;
        end else if (tok == CH_TIMES) begin
            r = m * n;
        end else begin
            if (n == '0) begin
                calc_err = ST_DIVZ;
                return;
            end
            r = trunc_div(m, n);
        end
        calc_depth -= 2;
        stack_push(r);
    endfunction

    function automatic void rpn_evaluate(logic [7:0] tok, logic last,
                                         output bit has_result, output calc_result_t res);
        logic [2:0] st;
        if (calc_err == ST_OK) begin
            apply_token(tok);
        end
        has_result = last;
        res.value = '0;
        res.status = ST_OK;
        if (!last) begin
            return;
        end
        st = calc_err;
        if (st == ST_OK && calc_depth == 0) begin
            st = ST_UNDER;
        end
        if (st == ST_OK) begin
            res.value = OUT_WIDTH'(calc_stack[calc_depth-1]);
        end
        res.status = st;
        calc_depth = 0;
        calc_err = ST_OK;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, msg);
        end
    endfunction

    task automatic add_tok(logic [7:0] tok, logic last);
        token_item_t t;
        t.token = tok;
        t.last = last;
        t.hold = drain_next;
        drain_next = 1'b0;
        token_queue.push_back(t);
    endtask

    // Well-formed expression with the given number of operands; push_all stacks them first.
    task automatic build_expr(int pushes, bit push_all);
        int depth;
        int left;
        depth = 0;
        left = pushes;
        while (left > 0 || depth > 1) begin
            if (depth >= 2 && (left == 0 || (!push_all && $urandom_range(0, 1) == 0))) begin
                expr_buf.push_back(random_op());
                depth--;
            end else begin
                expr_buf.push_back(digit($urandom_range(0, 9)));
                depth++;
                left--;
            end
        end
    endtask

    // Token driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (token_queue.size() == 0) begin
                s_valid <= 1'b0;
            end else if (token_queue[0].hold && (s_valid || expected_results.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                next_tx = token_queue.pop_front();
                s_valid <= 1'b1;
                s_token <= next_tx.token;
                s_last_token <= next_tx.last;
                if (token_queue.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 9);
                end
            end
        end
    end

    // Result sink backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_gap > 0 && token_queue.size() > QUIET_TAIL) begin
            ready_gap--;
            m_ready <= 1'b0;
        end else begin
            ready_gap = 0;
            m_ready <= 1'b1;
            if (token_queue.size() > QUIET_TAIL && $urandom_range(0, 6) == 0) begin
                ready_gap = $urandom_range(1, 9);
            end
        end
    end

    // Monitor: check results, then predict from the accepted token transaction.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: value %0d stat %0d",
                                           m_value, m_status));
                end else begin
                    want = expected_results.pop_front();
                    if (m_value !== want.value || m_status !== want.status) begin
                        note_failure($sformatf("mismatch: value exp %0d got %0d, stat exp %0d got %0d",
                                               want.value, m_value, want.status, m_status));
                    end
                end
            end
            if (s_valid && s_ready) begin
                rpn_evaluate(s_token, s_last_token, emits, got);
                if (emits) begin
                    expected_results.push_back(got);
                end
                accepted_count++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int kind;
        int pos;
        int target;
        bit mid_hold_done;
        mid_hold_done = 1'b0;

        // directed: 0 below 9, each operator, negative division, div by zero,
        // underflow with sticky error, invalid tokens at the edges
        add_tok(digit(0), 1'b0);
        add_tok(digit(9), 1'b1);
        add_tok(digit(3), 1'b0);
        add_tok(digit(4), 1'b0);
        add_tok(CH_PLUS, 1'b1);
        add_tok(digit(3), 1'b0);
        add_tok(digit(4), 1'b0);
        add_tok(CH_MINUS, 1'b1);
        add_tok(digit(9), 1'b0);
        add_tok(digit(9), 1'b0);
        add_tok(CH_TIMES, 1'b1);
        add_tok(digit(0), 1'b0);
        add_tok(digit(5), 1'b0);
        add_tok(CH_MINUS, 1'b0);
        add_tok(digit(2), 1'b0);
        add_tok(CH_DIV, 1'b1);
        add_tok(digit(7), 1'b0);
        add_tok(digit(0), 1'b0);
        add_tok(CH_DIV, 1'b1);
        add_tok(CH_PLUS, 1'b0);
        add_tok(digit(5), 1'b1);
        add_tok(CH_NINE + 8'd1, 1'b1);
        add_tok(8'h00, 1'b1);
        add_tok(8'hFF, 1'b1);

        target = token_queue.size() + RANDOM_ITEMS;
        drain_next = 1'b1;
        while (token_queue.size() < target) begin
            if (!mid_hold_done && token_queue.size() > target / 2) begin
                drain_next = 1'b1;
                mid_hold_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                build_expr($urandom_range(1, 6), 1'b0);
            end else if (kind < 72) begin
                build_expr($urandom_range(7, 14), 1'b0);
            end else if (kind < 74) begin
                build_expr($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 1), 1'b1);
            end else if (kind < 76) begin
                // 2^(W-1) wraps to the most negative word, then divide by -1
                expr_buf.push_back(digit(2));
                repeat (VALUE_WIDTH - 2) begin
                    expr_buf.push_back(digit(2));
                    expr_buf.push_back(CH_TIMES);
                end
                expr_buf.push_back(digit(0));
                expr_buf.push_back(digit(1));
                expr_buf.push_back(CH_MINUS);
                expr_buf.push_back(CH_DIV);
            end else if (kind < 86) begin
                repeat ($urandom_range(1, 5)) begin
                    expr_buf.push_back(8'($urandom_range(0, 255)));
                end
            end else begin
                build_expr($urandom_range(2, 8), 1'b0);
                pos = $urandom_range(0, expr_buf.size() - 1);
                case ($urandom_range(0, 2))
                    0: expr_buf[pos] = 8'($urandom_range(0, 255));
                    1: expr_buf.push_front(random_op());
                    default: begin
                        while (expr_buf.size() > pos + 1) begin
                            expr_buf.delete(expr_buf.size() - 1);
                        end
                    end
                endcase
            end
            for (int i = 0; i < expr_buf.size(); i++) begin
                add_tok(expr_buf[i], i == expr_buf.size() - 1);
            end
            expr_buf.delete();
        end
        total_items = token_queue.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (accepted_count != total_items) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
